### rtl/core/uxf_pkg.sv
// Shared constants and codes of the UART receive buffer with XON/XOFF flow control.
package uxf_pkg;

  // Buffer geometry. The ring holds at most DEPTH-1 bytes.
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = PTR_W + 1;

  // Field widths fixed by the interface.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEVEL_W = 6;
  localparam int unsigned CMP_W   = (FILL_W > LEVEL_W) ? FILL_W : LEVEL_W;

  // Request codes.
  localparam logic [1:0] REQ_RX   = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_FLOW = 2'd2;

  // Configuration register indexes.
  localparam int unsigned   CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WM = 2'd1;

  // Reset values of the watermarks.
  localparam logic [LEVEL_W-1:0] LOW_WM_RST  = 6'd16;
  localparam logic [LEVEL_W-1:0] HIGH_WM_RST = 6'd48;

  // Flow-control characters.
  localparam logic [BYTE_W-1:0] CHAR_XON  = 8'h11;
  localparam logic [BYTE_W-1:0] CHAR_XOFF = 8'h13;

endpackage

### rtl/core/uart_rx_fifo_xon_xoff_unit.sv
// Top level of the UART receive byte buffer with XON/XOFF software flow control.
//
// Usage: each request on the input channel (in_valid_i / in_stall_o) carries a
// request type and a byte. A received byte of XON or XOFF updates the
// remote-paused flag and is not stored; any other byte is written into the ring
// buffer, or dropped and flagged when the buffer is full. A pop request reads
// the oldest byte, and a flow check compares the fill level with the two
// watermarks and asks for XOFF or XON to be sent, with hysteresis.
// Every request produces exactly one result on the output channel
// (out_valid_o / out_stall_i), in the cycle after it is accepted.
// Throughput is one request per cycle while the receiver does not stall: the
// byte store is a single memory whose registered read port returns a popped
// byte at the same edge at which the rest of the result is registered, and
// write and read never hit the same entry in one request.
// When the receiver stalls, the result stays on the outputs and in_stall_o is
// raised, so no further request is accepted until the result is taken.
// Reset clears the pointers, both pause flags and the result valid, and loads
// the watermark defaults of 16 and 48. The byte store itself is not cleared.
// Watermarks are written through the configuration port, which is always
// ready; writes to an index beyond the two registers are ignored.
module uart_rx_fifo_xon_xoff_unit
  import uxf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BYTE_W-1:0]    pop_data_o,
  output logic                 pop_valid_o,
  output logic                 byte_dropped_o,
  output logic                 send_flow_o,
  output logic [BYTE_W-1:0]    flow_char_o,
  output logic                 remote_paused_o,
  output logic                 local_paused_o,
  output logic [LEVEL_W-1:0]   fill_level_o,
  output logic                 is_empty_o,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEVEL_W-1:0]   cfg_data_i
);

  // Byte store: one write port and one registered read port.
  logic [BYTE_W-1:0] byte_store_q [DEPTH];
  logic [BYTE_W-1:0] pop_rdata_q;

  // Control state.
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic               remote_xoff_q, remote_xoff_d;
  logic               sent_xoff_q, sent_xoff_d;
  logic               out_valid_q;
  logic [LEVEL_W-1:0] low_wm_q, high_wm_q;

  // Result flags of the last request.
  logic pop_valid_q, pop_valid_d;
  logic dropped_q, dropped_d;
  logic send_flow_q, send_flow_d;

  logic accept;
  logic mem_we, mem_re;
  logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
  logic [FILL_W-1:0] fill_cur, fill_out;
  logic [CMP_W-1:0]  fill_cmp, fill_out_ext;

  // Fill level modulo DEPTH, valid for depths that are not a power of two.
  function automatic logic [FILL_W-1:0] fill_of(logic [PTR_W-1:0] wp, logic [PTR_W-1:0] rp);
    logic [FILL_W-1:0] w_ext, r_ext;
    w_ext = {1'b0, wp};
    r_ext = {1'b0, rp};
    if (wp >= rp) begin
      fill_of = w_ext - r_ext;
    end else begin
      fill_of = w_ext + FILL_W'(DEPTH) - r_ext;
    end
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + PTR_W'(1);
    end
  endfunction

  // A new request is taken whenever the result register is free or being emptied.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign wr_ptr_inc = ptr_inc(wr_ptr_q);
  assign rd_ptr_inc = ptr_inc(rd_ptr_q);
  assign fill_cur   = fill_of(wr_ptr_q, rd_ptr_q);
  assign fill_cmp   = CMP_W'(fill_cur);

  always_comb begin
    wr_ptr_d      = wr_ptr_q;
    rd_ptr_d      = rd_ptr_q;
    remote_xoff_d = remote_xoff_q;
    sent_xoff_d   = sent_xoff_q;
    pop_valid_d   = 1'b0;
    dropped_d     = 1'b0;
    send_flow_d   = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    case (req_type_i)
      REQ_RX: begin
        if (rx_byte_i == CHAR_XON) begin
          remote_xoff_d = 1'b0;
        end else if (rx_byte_i == CHAR_XOFF) begin
          remote_xoff_d = 1'b1;
        end else if (wr_ptr_inc == rd_ptr_q) begin
          dropped_d = 1'b1;
        end else begin
          mem_we   = accept;
          wr_ptr_d = wr_ptr_inc;
        end
      end
      REQ_POP: begin
        if (wr_ptr_q != rd_ptr_q) begin
          mem_re      = accept;
          pop_valid_d = 1'b1;
          rd_ptr_d    = rd_ptr_inc;
        end
      end
      REQ_FLOW: begin
        if (sent_xoff_q && (fill_cmp <= CMP_W'(low_wm_q))) begin
          send_flow_d = 1'b1;
          sent_xoff_d = 1'b0;
        end else if (!sent_xoff_q && (fill_cmp > CMP_W'(high_wm_q))) begin
          send_flow_d = 1'b1;
          sent_xoff_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Memory access. A push and a pop never come in the same request, so the
  // read never sees a write to its own entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      byte_store_q[wr_ptr_q] <= rx_byte_i;
    end
    if (mem_re) begin
      pop_rdata_q <= byte_store_q[rd_ptr_q];
    end
  end

  // Result flags are payload and load only with an accepted request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_valid_q <= pop_valid_d;
      dropped_q   <= dropped_d;
      send_flow_q <= send_flow_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q      <= '0;
      rd_ptr_q      <= '0;
      remote_xoff_q <= 1'b0;
      sent_xoff_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        wr_ptr_q      <= wr_ptr_d;
        rd_ptr_q      <= rd_ptr_d;
        remote_xoff_q <= remote_xoff_d;
        sent_xoff_q   <= sent_xoff_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_wm_q  <= LOW_WM_RST;
      high_wm_q <= HIGH_WM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LOW_WM:  low_wm_q  <= cfg_data_i;
        CFG_HIGH_WM: high_wm_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The status fields follow the state registers, which change only together
  // with a new result, so they hold steady while the result waits.
  assign fill_out     = fill_of(wr_ptr_q, rd_ptr_q);
  assign fill_out_ext = CMP_W'(fill_out);

  assign out_valid_o     = out_valid_q;
  assign pop_valid_o     = pop_valid_q;
  assign pop_data_o      = pop_valid_q ? pop_rdata_q : '0;
  assign byte_dropped_o  = dropped_q;
  assign send_flow_o     = send_flow_q;
  // After a flow request, the new local pause flag tells which character it was.
  assign flow_char_o     = send_flow_q ? (sent_xoff_q ? CHAR_XOFF : CHAR_XON) : '0;
  assign remote_paused_o = remote_xoff_q;
  assign local_paused_o  = sent_xoff_q;
  assign fill_level_o    = fill_out_ext[LEVEL_W-1:0];
  assign is_empty_o      = (wr_ptr_q == rd_ptr_q);

endmodule

### dv/uxf_tb_pkg.sv
`timescale 1ns / 1ps
// Result type and scoreboard class for the UART receive buffer testbench.
package uxf_tb_pkg;
  import uxf_pkg::*;

  // Request code 3 is left unused by the block.
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Register indexes beyond the two watermarks, which the block ignores.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [BYTE_W-1:0]  pop_data;
    logic               pop_valid;
    logic               byte_dropped;
    logic               send_flow;
    logic [BYTE_W-1:0]  flow_char;
    logic               remote_paused;
    logic               local_paused;
    logic [LEVEL_W-1:0] fill_level;
    logic               is_empty;
  } fifo_resp_t;

  class rx_fifo_scoreboard;
    logic [BYTE_W-1:0]  byte_ring [DEPTH];
    int unsigned        wr_ptr;
    int unsigned        rd_ptr;
    bit                 remote_xoff;
    bit                 sent_xoff;
    logic [LEVEL_W-1:0] low_wm;
    logic [LEVEL_W-1:0] high_wm;
    fifo_resp_t         pending_resps [$];
    int unsigned        mismatches;

    function new();
      wr_ptr      = 0;
      rd_ptr      = 0;
      remote_xoff = 1'b0;
      sent_xoff   = 1'b0;
      low_wm      = LOW_WM_RST;
      high_wm     = HIGH_WM_RST;
      mismatches  = 0;
    endfunction

    function void set_watermark(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
      case (idx)
        CFG_LOW_WM:  low_wm = val;
        CFG_HIGH_WM: high_wm = val;
        default: ;
      endcase
    endfunction

    function int unsigned stored_count();
      return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    endfunction

    // Updates the buffer state for one accepted request and queues its result.
    function void note_request(logic [1:0] req, logic [BYTE_W-1:0] rx_byte);
      fifo_resp_t  resp;
      int unsigned level;
      resp = '0;
      case (req)
        REQ_RX: begin
          if (rx_byte == CHAR_XON) begin
            remote_xoff = 1'b0;
          end else if (rx_byte == CHAR_XOFF) begin
            remote_xoff = 1'b1;
          end else if ((wr_ptr + 1) % DEPTH == rd_ptr) begin
            resp.byte_dropped = 1'b1;
          end else begin
            byte_ring[wr_ptr] = rx_byte;
            wr_ptr = (wr_ptr + 1) % DEPTH;
          end
        end
        REQ_POP: begin
          if (wr_ptr != rd_ptr) begin
            resp.pop_data  = byte_ring[rd_ptr];
            resp.pop_valid = 1'b1;
            rd_ptr = (rd_ptr + 1) % DEPTH;
          end
        end
        REQ_FLOW: begin
          level = stored_count();
          if (sent_xoff && level <= low_wm) begin
            resp.send_flow = 1'b1;
            resp.flow_char = CHAR_XON;
            sent_xoff = 1'b0;
          end else if (!sent_xoff && level > high_wm) begin
            resp.send_flow = 1'b1;
            resp.flow_char = CHAR_XOFF;
            sent_xoff = 1'b1;
          end
        end
        default: ;
      endcase
      level = stored_count();
      resp.remote_paused = remote_xoff;
      resp.local_paused  = sent_xoff;
      resp.fill_level    = level[LEVEL_W-1:0];
      resp.is_empty      = (level == 0);
      pending_resps.push_back(resp);
    endfunction

    function string describe(fifo_resp_t r);
      return $sformatf("data=%02h pv=%0b drop=%0b flow=%0b char=%02h rp=%0b lp=%0b fill=%0d empty=%0b",
                       r.pop_data, r.pop_valid, r.byte_dropped, r.send_flow, r.flow_char,
                       r.remote_paused, r.local_paused, r.fill_level, r.is_empty);
    endfunction

    // Compares one accepted result with the oldest queued expectation.
    function void check_result(fifo_resp_t got);
      fifo_resp_t want;
      if (pending_resps.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result with no request waiting: %s", describe(got));
        return;
      end
      want = pending_resps.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result mismatch\n  expected %s\n  actual   %s",
                   describe(want), describe(got));
      end
    endfunction
  endclass

endpackage

### dv/uart_rx_fifo_xon_xoff_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top: directed and random requests into the receive buffer, every result checked.
module uart_rx_fifo_xon_xoff_unit_tb;
  import uxf_pkg::*;
  import uxf_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 255;
  localparam int unsigned RANDOM_PHASES   = 7;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 8;

  // Traffic shapes of the random part. Fill runs push the ring up to full and
  // into drops, drain runs empty it and pop past the last byte.
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_e;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         req_type;
  logic [BYTE_W-1:0]  rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [BYTE_W-1:0]  pop_data;
  logic               pop_valid;
  logic               byte_dropped;
  logic               send_flow;
  logic [BYTE_W-1:0]  flow_char;
  logic               remote_paused;
  logic               local_paused;
  logic [LEVEL_W-1:0] fill_level;
  logic               is_empty;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0] cfg_data;

  // When quiet is set, neither side idles. hold_off_req asks the result side
  // for one long stall so that the single result register backs up.
  bit                 quiet;
  bit                 hold_off_req;
  int unsigned        cycle_count;

  rx_fifo_scoreboard  sb;

  uart_rx_fifo_xon_xoff_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .pop_data_o      (pop_data),
    .pop_valid_o     (pop_valid),
    .byte_dropped_o  (byte_dropped),
    .send_flow_o     (send_flow),
    .flow_char_o     (flow_char),
    .remote_paused_o (remote_paused),
    .local_paused_o  (local_paused),
    .fill_level_o    (fill_level),
    .is_empty_o      (is_empty),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog. A correct run needs only a small fraction of this budget.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Sends one request. Sometimes the valid line drops for a random gap
  // first; otherwise it stays high so requests go back to back. The request
  // is handed to the scoreboard at the edge where it is accepted, which is
  // always before the edge at which its result can be taken.
  task automatic send_request(input logic [1:0] req, input logic [BYTE_W-1:0] data);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    rx_byte  <= data;
    do @(posedge clk); while (in_stall);
    sb.note_request(req, data);
  endtask

  // Lowers the request valid and waits until every result has come back, then
  // lets the clock run on for DRAIN_CYCLES so the block is certainly at rest.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_resps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write. The valid line is left high so writes can follow
  // each other; program_watermarks lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_watermark(idx, val);
  endtask

  // Writes both watermarks; optionally also the unused indexes, which must
  // leave the watermarks untouched.
  task automatic program_watermarks(input logic [LEVEL_W-1:0] low_val,
                                    input logic [LEVEL_W-1:0] high_val,
                                    input bit touch_spare);
    write_reg(CFG_LOW_WM, low_val);
    write_reg(CFG_HIGH_WM, high_val);
    if (touch_spare) begin
      write_reg(CFG_SPARE_A, LEVEL_W'($urandom_range(0, 63)));
      write_reg(CFG_SPARE_B, LEVEL_W'($urandom_range(0, 63)));
    end
    cfg_valid <= 1'b0;
  endtask

  // Random traffic in runs of one shape. About one received byte in ten is
  // an XON or XOFF so the remote pause flag toggles often.
  task automatic run_random_phase(input int unsigned n_items);
    traffic_mix_e      mix;
    int unsigned       run_left;
    int unsigned       roll;
    int unsigned       rx_share;
    int unsigned       pop_share;
    logic [1:0]        req;
    logic [BYTE_W-1:0] data;
    run_left = 0;
    mix = MIX_BALANCED;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        mix = traffic_mix_e'($urandom_range(0, 2));
        run_left = $urandom_range(10, 90);
      end
      run_left--;
      case (mix)
        MIX_FILL: begin
          rx_share = 75;
          pop_share = 85;
        end
        MIX_DRAIN: begin
          rx_share = 15;
          pop_share = 80;
        end
        default: begin
          rx_share = 45;
          pop_share = 80;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < rx_share) req = REQ_RX;
      else if (roll < pop_share) req = REQ_POP;
      else if (roll < 97) req = REQ_FLOW;
      else req = REQ_NONE;
      roll = $urandom_range(0, 19);
      if (roll == 0) data = CHAR_XON;
      else if (roll == 1) data = CHAR_XOFF;
      else data = BYTE_W'($urandom_range(0, 255));
      send_request(req, data);
    end
  endtask

  // Result side: random stall bursts, plus the one long hold-off on request.
  // While it lasts the result register stays full, in_stall rises and the
  // request side keeps offering its next request.
  initial begin
    int unsigned burst;
    int unsigned held;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Every result taken at an edge goes to the scoreboard. Outputs are read
  // right after the edge, so they still hold the values seen at that edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{pop_data: pop_data, pop_valid: pop_valid,
                        byte_dropped: byte_dropped, send_flow: send_flow,
                        flow_char: flow_char, remote_paused: remote_paused,
                        local_paused: local_paused, fill_level: fill_level,
                        is_empty: is_empty});
    end
  end

  initial begin
    sb = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    req_type     = REQ_RX;
    rx_byte      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_LOW_WM;
    cfg_data     = '0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset watermarks: pop and flow check on an
    // empty ring, the unused request code, and a first stored byte.
    send_request(REQ_POP, 8'h00);
    send_request(REQ_FLOW, 8'h00);
    send_request(REQ_NONE, 8'hFF);
    send_request(REQ_RX, 8'h00);
    wait_idle();

    // Tight watermarks so that a handful of bytes crosses both of them.
    program_watermarks(6'd1, 6'd3, 1'b1);
    send_request(REQ_RX, 8'hFF);
    send_request(REQ_RX, CHAR_XOFF);
    send_request(REQ_RX, 8'h12);
    send_request(REQ_RX, 8'h14);
    // Four bytes stored, above the high watermark: XOFF goes out, and a
    // second check must not repeat it.
    send_request(REQ_FLOW, 8'h00);
    send_request(REQ_RX, CHAR_XON);
    send_request(REQ_FLOW, 8'h00);
    send_request(REQ_POP, 8'h00);
    send_request(REQ_POP, 8'h00);
    send_request(REQ_POP, 8'h00);
    // One byte left, at the low watermark: XON goes out.
    send_request(REQ_FLOW, 8'h00);
    send_request(REQ_POP, 8'h00);
    // Pop on the now empty ring must not move the read pointer.
    send_request(REQ_POP, 8'h00);
    send_request(REQ_NONE, 8'hAA);
    send_request(REQ_RX, 8'h55);

    // Random phases, each under its own watermark setting, including both
    // extremes and an inverted pair. The last one runs without any idling.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          program_watermarks(LOW_WM_RST, HIGH_WM_RST, 1'b0);
        end
        1: begin
          program_watermarks(6'd0, 6'd63, 1'b0);
        end
        2: begin
          program_watermarks(6'd63, 6'd0, 1'b0);
          hold_off_req = 1'b1;
        end
        3: begin
          program_watermarks(6'd0, 6'd0, 1'b0);
        end
        4: begin
          program_watermarks(6'd63, 6'd63, 1'b0);
        end
        5: begin
          program_watermarks(LEVEL_W'($urandom_range(0, 63)),
                             LEVEL_W'($urandom_range(0, 63)), 1'b1);
        end
        default: begin
          program_watermarks(LEVEL_W'($urandom_range(0, 63)),
                             LEVEL_W'($urandom_range(0, 63)), 1'b0);
          quiet = 1'b1;
        end
      endcase
      run_random_phase(ITEMS_PER_PHASE);
    end
    wait_idle();

    if (sb.mismatches == 0 && sb.pending_resps.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
